### sv/block_range_extent_mapper_assert.svh
// Assertion helpers for the extent mapper
`ifndef BLOCK_RANGE_EXTENT_MAPPER_ASSERT_SVH
`define BLOCK_RANGE_EXTENT_MAPPER_ASSERT_SVH
`ifndef SYNTH
`define BREM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BREM_ASSERT(lbl, prop, msg) \
  `BREM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define BREM_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define BREM_ASSERT(lbl, prop, msg)
`endif
`endif

### sv/brem_pkg.sv
`default_nettype none
package brem_pkg;
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } brem_op_e;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EARLY = 2'd2;
  localparam logic [1:0] STAT_TRUNC = 2'd3;

  typedef struct packed {
    logic [31:0]        start;
    logic [31:0]        length;
    logic signed [47:0] offset;
    logic [31:0]        owner;
  } brem_entry_t;
endpackage
`default_nettype wire

### sv/brem_table.sv
`default_nettype none
module brem_table #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned IW    = 12
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [IW-1:0]            waddr_i,
  input  wire  brem_pkg::brem_entry_t wdata_i,
  input  wire  [IW-1:0]            raddr_i,
  output brem_pkg::brem_entry_t    rdata_o
);
  import brem_pkg::*;

  brem_entry_t mem_q [DEPTH];
  brem_entry_t rdata_q;

  // write one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

### sv/block_range_extent_mapper.sv
// Extent table mapper.
// Command channel: drive the item fields with start while busy is low; the
// beat is taken at that edge and busy rises on the next cycle.
// Load appends one block (merged into the last extent where it continues it),
// clear empties the table, query splits a sector range into pieces. Every item
// answers with one or more result beats on res_valid_o, one cycle each, the
// final one with last_o. The receiver cannot hold results off.
// Configuration: cfg_valid_i with cfg_index_i/cfg_data_i, always ready; index 0
// is the partition base sector, index 1 is sector_shift. Write only while idle.
// Query sequencing: per piece, one binary search of up to log2(TABLE_ENTRIES)+1
// probes through the single registered read port of the extent memory, then
// the piece work; the final piece goes out as the closing beat with last_o.
// At most MAX_PIECES pieces; the last one is flagged truncated if blocks remain.
// Reset empties the table (count only; entries are not cleared) and sets
// the partition base to 0, sector_shift to 3. No clearing pass is needed.
`default_nettype none
module block_range_extent_mapper #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned MAX_PIECES    = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         opcode_i,
  input  wire  [31:0]        entry_block_i,
  input  wire  signed [47:0] entry_offset_i,
  input  wire  [31:0]        entry_inode_i,
  input  wire  [47:0]        query_sector_i,
  input  wire  [31:0]        query_length_i,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  [0:0]         cfg_index_i,
  input  wire  [47:0]        cfg_data_i,
  output logic               res_valid_o,
  output logic [31:0]        piece_start_o,
  output logic [31:0]        piece_length_o,
  output logic               is_mapped_o,
  output logic signed [47:0] file_offset_o,
  output logic [31:0]        owner_inode_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import brem_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LW = CW + 2;
  localparam int unsigned NW = $clog2(MAX_PIECES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_PIECES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_CHK, ST_Q_PRE, ST_Q_CLIP, ST_P_TOP, ST_S_ISS, ST_S_CMP,
    ST_S_LO, ST_P_GAP, ST_P_MAP, ST_FIN, ST_ONE
  } state_e;

  state_e             state_q;
  logic [31:0]        blk_q, ino_q, qlen_q;
  logic signed [47:0] off_q;
  logic [47:0]        sec_q, ps_q;
  logic [2:0]         sh_q;
  logic [CW-1:0]      count_q;
  logic [32:0]        b_q, len_q;
  logic signed [LW-1:0] lo_q, hi_q;
  logic               xv_q;
  brem_entry_t        ent_q;
  logic [NW-1:0]      n_q;
  logic [1:0]         stat_q;
  logic               pv_q, pmap_q;
  logic [31:0]        pst_q, plen_q, pino_q;
  logic signed [47:0] poff_q;
  logic [1:0]         pstat_q;
  logic               rv_q, rmap_q, rlast_q;
  logic [31:0]        rst_q, rlen_q, rino_q;
  logic signed [47:0] roff_q;
  logic [1:0]         rstat_q;

  brem_entry_t        rdata, wdata;
  logic               we;
  logic [IW-1:0]      waddr, raddr;

  brem_table #(.DEPTH(TABLE_ENTRIES), .IW(IW)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // load merge check against the last extent
  logic [32:0]        ld_end;
  logic signed [49:0] ld_offend;
  logic               merge;
  logic [CW-1:0]      last_idx;
  assign last_idx  = count_q - CW'(1);
  assign ld_end    = {1'b0, rdata.start} + {1'b0, rdata.length};
  assign ld_offend = 50'(rdata.offset) + $signed({18'b0, rdata.length});
  assign merge = (count_q != '0) && (rdata.owner == ino_q) && !off_q[47] &&
                 (rdata.length != 32'hFFFF_FFFF) && (ld_end == {1'b0, blk_q}) &&
                 (ld_offend == 50'(off_q));

  // search probe
  logic signed [LW-1:0] sum;
  logic [IW-1:0]        mid;
  logic [32:0]          r_end;
  logic                 contains, less, lo_le_hi, lo_past;
  assign sum      = lo_q + hi_q;
  assign mid      = sum[IW:1];
  assign r_end    = {1'b0, rdata.start} + {1'b0, rdata.length};
  assign contains = ({1'b0, rdata.start} <= b_q) && (r_end > b_q);
  assign less     = {1'b0, rdata.start} < b_q;
  assign lo_le_hi = lo_q <= hi_q;
  assign lo_past  = lo_q >= $signed({2'b0, count_q});

  // piece arithmetic
  logic [32:0] es33, e_end, gap, gap_cur, dlt, rem, map_cur, cur, len_nx, b_nx;
  logic        past_ext, ahead;
  logic signed [47:0] map_off;
  assign es33     = {1'b0, ent_q.start};
  assign e_end    = es33 + {1'b0, ent_q.length};
  assign past_ext = !xv_q || ((es33 <= b_q) && (e_end <= b_q));
  assign ahead    = b_q < es33;
  assign gap      = es33 - b_q;
  assign gap_cur  = (gap < len_q) ? gap : len_q;
  assign dlt      = b_q - es33;
  assign rem      = {1'b0, ent_q.length} - dlt;
  assign map_cur  = (len_q < rem) ? len_q : rem;
  assign cur      = (state_q == ST_P_GAP) ? gap_cur : map_cur;
  assign len_nx   = len_q - cur;
  assign b_nx     = b_q + cur;
  assign map_off  = ent_q.offset + $signed({15'b0, dlt});

  // query rebase
  logic [47:0] diff, diff_sh;
  logic [33:0] q_end;
  assign diff    = sec_q - ps_q;
  assign diff_sh = diff >> sh_q;
  assign q_end   = {1'b0, b_q} + {1'b0, len_q};

  // memory ports
  always_comb begin
    we    = 1'b0;
    waddr = count_q[IW-1:0];
    wdata = '{start: blk_q, length: 32'd1, offset: off_q, owner: ino_q};
    raddr = '0;
    if (state_q == ST_LD_CHK) begin
      if (merge) begin
        we    = 1'b1;
        waddr = last_idx[IW-1:0];
        wdata = rdata;
        wdata.length = rdata.length + 32'd1;
      end else if (count_q < FULL_COUNT) begin
        we = 1'b1;
      end
    end
    case (state_q)
      ST_IDLE:  raddr = last_idx[IW-1:0];
      ST_S_ISS: raddr = lo_le_hi ? mid : lo_q[IW-1:0];
      default:  raddr = '0;
    endcase
  end

  // sequencer, table count, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ps_q    <= '0;
      sh_q    <= 3'd3;
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
      n_q     <= '0;
    end else begin
      rv_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == 1'b0) ps_q <= cfg_data_i;
        else                     sh_q <= cfg_data_i[2:0];
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            blk_q  <= entry_block_i;
            off_q  <= entry_offset_i;
            ino_q  <= entry_inode_i;
            sec_q  <= query_sector_i;
            qlen_q <= query_length_i;
            stat_q <= STAT_OK;
            unique case (brem_op_e'(opcode_i))
              OP_LOAD:  state_q <= ST_LD_CHK;
              OP_QUERY: state_q <= ST_Q_PRE;
              OP_CLEAR: begin
                count_q <= '0;
                state_q <= ST_ONE;
              end
              default:  state_q <= ST_ONE;
            endcase
          end
        end
        ST_LD_CHK: begin
          if (!merge) begin
            if (count_q < FULL_COUNT) count_q <= count_q + CW'(1);
            else                      stat_q  <= STAT_FULL;
          end
          state_q <= ST_ONE;
        end
        ST_Q_PRE: begin
          if (sec_q < ps_q) begin
            stat_q  <= STAT_EARLY;
            state_q <= ST_ONE;
          end else begin
            b_q     <= {1'b0, diff_sh[31:0]};
            len_q   <= {1'b0, qlen_q >> sh_q};
            n_q     <= '0;
            pv_q    <= 1'b0;
            state_q <= ST_Q_CLIP;
          end
        end
        ST_Q_CLIP: begin
          if (q_end > 34'h1_0000_0000) len_q <= 33'h1_0000_0000 - b_q;
          if (len_q == '0) begin
            pv_q    <= 1'b1;
            pst_q   <= b_q[31:0];
            plen_q  <= '0;
            pmap_q  <= 1'b0;
            poff_q  <= '0;
            pino_q  <= '0;
            pstat_q <= STAT_OK;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_P_TOP;
          end
        end
        ST_P_TOP: begin
          lo_q <= '0;
          hi_q <= $signed({2'b0, count_q}) - LW'(1);
          if (len_q == '0) begin
            state_q <= ST_FIN;
          end else if (n_q == MAX_N) begin
            pstat_q <= STAT_TRUNC;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_S_ISS;
          end
        end
        ST_S_ISS: begin
          if (lo_le_hi) begin
            state_q <= ST_S_CMP;
          end else if (lo_past) begin
            xv_q    <= 1'b0;
            state_q <= ST_P_GAP;
          end else begin
            state_q <= ST_S_LO;
          end
        end
        ST_S_CMP: begin
          if (contains) begin
            ent_q   <= rdata;
            xv_q    <= 1'b1;
            state_q <= ST_P_GAP;
          end else begin
            if (less) lo_q <= $signed({{(LW-IW){1'b0}}, mid}) + LW'(1);
            else      hi_q <= $signed({{(LW-IW){1'b0}}, mid}) - LW'(1);
            state_q <= ST_S_ISS;
          end
        end
        ST_S_LO: begin
          ent_q   <= rdata;
          xv_q    <= 1'b1;
          state_q <= ST_P_GAP;
        end
        ST_P_GAP, ST_P_MAP: begin
          if (state_q == ST_P_GAP && !past_ext && !ahead) begin
            state_q <= ST_P_MAP;
          end else begin
            // hand the held piece out and hold the new one
            if (pv_q) begin
              rv_q    <= 1'b1;
              rst_q   <= pst_q;
              rlen_q  <= plen_q;
              rmap_q  <= pmap_q;
              roff_q  <= poff_q;
              rino_q  <= pino_q;
              rstat_q <= pstat_q;
              rlast_q <= 1'b0;
            end
            pv_q    <= 1'b1;
            pst_q   <= b_q[31:0];
            pstat_q <= STAT_OK;
            n_q     <= n_q + NW'(1);
            if (state_q == ST_P_MAP) begin
              plen_q  <= map_cur[31:0];
              pmap_q  <= 1'b1;
              poff_q  <= map_off;
              pino_q  <= ent_q.owner;
              len_q   <= len_nx;
              b_q     <= b_nx;
              state_q <= ST_P_TOP;
            end else if (past_ext) begin
              plen_q  <= len_q[31:0];
              pmap_q  <= 1'b0;
              poff_q  <= '0;
              pino_q  <= '0;
              len_q   <= '0;
              state_q <= ST_FIN;
            end else begin
              plen_q  <= gap_cur[31:0];
              pmap_q  <= 1'b0;
              poff_q  <= '0;
              pino_q  <= '0;
              len_q   <= len_nx;
              b_q     <= b_nx;
              if (len_nx == '0) begin
                state_q <= ST_FIN;
              end else if (n_q + NW'(1) == MAX_N) begin
                pstat_q <= STAT_TRUNC;
                state_q <= ST_FIN;
              end else begin
                state_q <= ST_P_MAP;
              end
            end
          end
        end
        ST_FIN: begin
          rv_q    <= 1'b1;
          rst_q   <= pst_q;
          rlen_q  <= plen_q;
          rmap_q  <= pmap_q;
          roff_q  <= poff_q;
          rino_q  <= pino_q;
          rstat_q <= pstat_q;
          rlast_q <= 1'b1;
          pv_q    <= 1'b0;
          state_q <= ST_IDLE;
        end
        ST_ONE: begin
          rv_q    <= 1'b1;
          rst_q   <= '0;
          rlen_q  <= '0;
          rmap_q  <= 1'b0;
          roff_q  <= '0;
          rino_q  <= '0;
          rstat_q <= stat_q;
          rlast_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy           = state_q != ST_IDLE;
  assign cfg_ready_o    = 1'b1;
  assign res_valid_o    = rv_q;
  assign piece_start_o  = rst_q;
  assign piece_length_o = rlen_q;
  assign is_mapped_o    = rmap_q;
  assign file_offset_o  = roff_q;
  assign owner_inode_o  = rino_q;
  assign status_o       = rstat_q;
  assign last_o         = rlast_q;

`include "block_range_extent_mapper_assert.svh"
  `BREM_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `BREM_ASSERT(a_res_after_busy, res_valid_o |-> $past(busy), "result beat while idle")
  `BREM_ASSERT(a_count_range, count_q <= FULL_COUNT, "extent count beyond table size")
  `BREM_ASSERT(a_piece_range, n_q <= MAX_N, "piece count beyond limit")
endmodule
`default_nettype wire

### sim/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brem_pkg::*;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned PIECE_LIMIT = 64;
  localparam int unsigned FILL_COUNT = 64;
  localparam logic [0:0]  REG_PART_START = 1'b0;
  localparam logic [0:0]  REG_SECTOR_SHIFT = 1'b1;
  localparam int          STALL_LIMIT = 20000;
  localparam logic [47:0] SECTOR_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] OFFSET_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] OFFSET_MIN = 48'h8000_0000_0000;

  typedef struct {
    brem_op_e    op;
    logic [31:0] blk;
    logic [47:0] off;
    logic [31:0] ino;
    logic [47:0] sec;
    logic [31:0] qlen;
  } cmd_t;

  typedef struct {
    logic [31:0] pstart;
    logic [31:0] plen;
    logic        mapped;
    logic [47:0] foff;
    logic [31:0] owner;
    logic [1:0]  status;
    logic        last;
  } piece_t;

  typedef struct {
    bit          is_reg;
    logic [0:0]  reg_idx;
    logic [47:0] reg_val;
    cmd_t        cmd;
    bit          typed;
    logic [1:0]  typed_status;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode_i = '0;
  logic [31:0] entry_block_i = '0;
  logic signed [47:0] entry_offset_i = '0;
  logic [31:0] entry_inode_i = '0;
  logic [47:0] query_sector_i = '0;
  logic [31:0] query_length_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic res_valid_o;
  logic [31:0] piece_start_o, piece_length_o, owner_inode_o;
  logic is_mapped_o, last_o;
  logic signed [47:0] file_offset_o;
  logic [1:0] status_o;

  block_range_extent_mapper DUT (.*);

  // Mirror of the extent table and registers
  logic [31:0] ext_start [TABLE_DEPTH];
  logic [31:0] ext_len [TABLE_DEPTH];
  logic [47:0] ext_off [TABLE_DEPTH];
  logic [31:0] ext_owner [TABLE_DEPTH];
  int unsigned ext_count = 0;
  logic [47:0] part_start = '0;
  logic [2:0]  blk_shift = 3'd3;

  piece_t pending_pieces[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  // Random sequence state
  longint unsigned seq_blk = 100;
  longint seq_off = 0;
  logic [31:0] seq_ino = 1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint sext48(logic [47:0] v);
    return longint'({{16{v[47]}}, v});
  endfunction

  function automatic piece_t make_piece(longint unsigned b, longint unsigned n,
                                        logic m, longint o, logic [31:0] ino,
                                        logic [1:0] st);
    piece_t p;
    p.pstart = b[31:0];
    p.plen = n[31:0];
    p.mapped = m;
    p.foff = o[47:0];
    p.owner = ino;
    p.status = st;
    p.last = 1'b0;
    return p;
  endfunction

  function automatic piece_t status_only(logic [1:0] st);
    piece_t p;
    p = make_piece(0, 0, 1'b0, 0, '0, st);
    p.last = 1'b1;
    return p;
  endfunction

  // Containing extent, else first one after the search point; -1 if none
  function automatic int find_extent(longint unsigned b);
    int lo, hi, mid;
    longint unsigned s;
    lo = 0;
    hi = int'(ext_count) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      s = ext_start[mid];
      if (s <= b && s + ext_len[mid] > b) return mid;
      if (s < b) lo = mid + 1;
      else hi = mid - 1;
    end
    if (lo >= int'(ext_count)) return -1;
    return lo;
  endfunction

  function automatic void map_load(cmd_t c);
    int unsigned i;
    longint unsigned n;
    longint o;
    o = sext48(c.off);
    if (ext_count > 0) begin
      i = ext_count - 1;
      n = ext_len[i];
      if (ext_owner[i] == c.ino && o >= 0 && n < 64'hFFFF_FFFF &&
          longint'(ext_start[i]) + n == longint'(c.blk) &&
          sext48(ext_off[i]) + longint'(n) == o) begin
        ext_len[i] = ext_len[i] + 32'd1;
        pending_pieces.push_back(status_only(STAT_OK));
        return;
      end
    end
    if (ext_count >= TABLE_DEPTH) begin
      pending_pieces.push_back(status_only(STAT_FULL));
      return;
    end
    ext_start[ext_count] = c.blk;
    ext_len[ext_count] = 32'd1;
    ext_off[ext_count] = c.off;
    ext_owner[ext_count] = c.ino;
    ext_count++;
    pending_pieces.push_back(status_only(STAT_OK));
  endfunction

  function automatic void map_query(cmd_t c);
    longint unsigned b, n, es, el, cur;
    int x;
    piece_t q[$];
    if (c.sec < part_start) begin
      pending_pieces.push_back(status_only(STAT_EARLY));
      return;
    end
    b = ((longint'(c.sec) - longint'(part_start)) >> blk_shift) & 64'hFFFF_FFFF;
    n = longint'(c.qlen) >> blk_shift;
    if (b + n > 64'h1_0000_0000) n = 64'h1_0000_0000 - b;
    if (n == 0) q.push_back(make_piece(b, 0, 1'b0, 0, '0, STAT_OK));
    while (n > 0) begin
      if (q.size() == PIECE_LIMIT) begin
        q[$].status = STAT_TRUNC;
        break;
      end
      x = find_extent(b);
      es = (x < 0) ? 0 : ext_start[x];
      el = (x < 0) ? 0 : ext_len[x];
      if (x < 0 || (es <= b && es + el <= b)) begin
        q.push_back(make_piece(b, n, 1'b0, 0, '0, STAT_OK));
        break;
      end
      // Leading hole before the extent
      if (b < es) begin
        cur = (es - b < n) ? es - b : n;
        q.push_back(make_piece(b, cur, 1'b0, 0, '0, STAT_OK));
        n -= cur;
        b += cur;
        if (n == 0) break;
        if (q.size() == PIECE_LIMIT) begin
          q[$].status = STAT_TRUNC;
          break;
        end
      end
      cur = el - (b - es);
      if (n < cur) cur = n;
      q.push_back(make_piece(b, cur, 1'b1, sext48(ext_off[x]) + longint'(b - es),
                             ext_owner[x], STAT_OK));
      n -= cur;
      b += cur;
    end
    q[$].last = 1'b1;
    foreach (q[k]) pending_pieces.push_back(q[k]);
  endfunction

  function automatic void map_command(cmd_t c);
    case (c.op)
      OP_LOAD:  map_load(c);
      OP_QUERY: map_query(c);
      OP_CLEAR: begin
        ext_count = 0;
        pending_pieces.push_back(status_only(STAT_OK));
      end
      default:  pending_pieces.push_back(status_only(STAT_OK));
    endcase
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check each result beat against the oldest expectation; guard progress
  always @(posedge clk_i) begin
    piece_t w;
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (res_valid_o) begin
        if (pending_pieces.size() == 0) begin
          report("unexpected beat, start", piece_start_o, 0);
        end else begin
          w = pending_pieces.pop_front();
          if (piece_start_o !== w.pstart) report("piece_start", piece_start_o, w.pstart);
          if (piece_length_o !== w.plen) report("piece_length", piece_length_o, w.plen);
          if (is_mapped_o !== w.mapped) report("is_mapped", is_mapped_o, w.mapped);
          if (file_offset_o !== w.foff) report("file_offset", file_offset_o, w.foff);
          if (owner_inode_o !== w.owner) report("owner_inode", owner_inode_o, w.owner);
          if (status_o !== w.status) report("status", status_o, w.status);
          if (last_o !== w.last) report("last", last_o, w.last);
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_command(cmd_t c);
    int gap;
    @(negedge clk_i);
    start = 1'b1;
    opcode_i = c.op;
    entry_block_i = c.blk;
    entry_offset_i = c.off;
    entry_inode_i = c.ino;
    query_sector_i = c.sec;
    query_length_i = c.qlen;
    do @(posedge clk_i); while (busy);
    map_command(c);
    // Hold off the next beat now and then
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (pending_pieces.size() != 0 || busy);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [47:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_PART_START) part_start = val;
    else blk_shift = val[2:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic cmd_t cmd(brem_op_e op, logic [31:0] blk, logic [47:0] off,
                               logic [31:0] ino, logic [47:0] sec, logic [31:0] qlen);
    cmd_t c;
    c.op = op;
    c.blk = blk;
    c.off = off;
    c.ino = ino;
    c.sec = sec;
    c.qlen = qlen;
    return c;
  endfunction

  function automatic step_t do_cmd(cmd_t c, bit typed, logic [1:0] st);
    step_t s;
    s.is_reg = 1'b0;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.cmd = c;
    s.typed = typed;
    s.typed_status = st;
    return s;
  endfunction

  function automatic step_t do_reg(logic [0:0] idx, logic [47:0] val);
    step_t s;
    s = do_cmd(cmd(OP_NOP, 0, 0, 0, 0, 0), 1'b0, STAT_OK);
    s.is_reg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int r, k;
    longint unsigned b;
    r = $urandom_range(99);
    c = cmd(OP_NOP, $urandom, {$urandom, $urandom}, $urandom, {$urandom, $urandom},
            $urandom);
    if (r < 8) begin
      // Noise: every field at random
      c.op = brem_op_e'($urandom_range(3));
    end else if (r < 60 && ext_count < 1500) begin
      c.op = OP_LOAD;
      k = $urandom_range(9);
      if (k >= 6 && k < 8) begin
        seq_blk += $urandom_range(1, 20);
        seq_ino = $urandom_range(1, 5);
        seq_off = $urandom_range(0, 1000);
      end
      c.blk = seq_blk[31:0];
      c.off = seq_off[47:0];
      c.ino = seq_ino;
      if (k == 8) c.off = -longint'($urandom_range(1, 50));
      if (k == 9) c.blk = $urandom_range(0, seq_blk[31:0]);
      seq_blk = c.blk + 1;
      seq_off = sext48(c.off) + 1;
    end else if (r < 95) begin
      c.op = OP_QUERY;
      b = $urandom_range(0, seq_blk[31:0] + 10);
      c.sec = part_start + (b << blk_shift) + $urandom_range(0, (1 << blk_shift) - 1);
      if ($urandom_range(9) != 0)
        c.qlen = ($urandom_range(0, 150) << blk_shift) + $urandom_range(0, 7);
    end else if (r < 98) begin
      c.op = OP_CLEAR;
      seq_blk = $urandom_range(0, 1000);
    end
    if (c.op == OP_CLEAR || (ext_count >= 1500 && c.op == OP_LOAD)) begin
      c.op = OP_CLEAR;
      seq_blk = $urandom_range(0, 1000);
    end
    return c;
  endfunction

  initial begin
    step_t steps[$];
    int base;
    steps = '{
      do_cmd(cmd(OP_NOP, '1, OFFSET_MIN, '1, SECTOR_MAX, '1), 1'b1, STAT_OK),
      do_cmd(cmd(OP_CLEAR, 0, 0, 0, 0, 0), 1'b1, STAT_OK),
      do_cmd(cmd(OP_QUERY, 0, 0, 0, 0, 0), 1'b0, STAT_OK),
      do_cmd(cmd(OP_LOAD, 10, 0, 1, 0, 0), 1'b1, STAT_OK),
      do_cmd(cmd(OP_LOAD, 11, 1, 1, 0, 0), 1'b1, STAT_OK),
      do_cmd(cmd(OP_LOAD, 12, 48'hFFFF_FFFF_FFFF, 1, 0, 0), 1'b1, STAT_OK),
      do_cmd(cmd(OP_LOAD, 13, 0, 2, 0, 0), 1'b1, STAT_OK),
      do_cmd(cmd(OP_LOAD, 14, 0, 3, 0, 0), 1'b1, STAT_OK),
      do_cmd(cmd(OP_LOAD, 20, OFFSET_MAX, '1, 0, 0), 1'b1, STAT_OK),
      do_cmd(cmd(OP_LOAD, '1, OFFSET_MIN, 0, 0, 0), 1'b1, STAT_OK),
      do_cmd(cmd(OP_QUERY, 0, 0, 0, 0, '1), 1'b0, STAT_OK),
      do_cmd(cmd(OP_QUERY, 0, 0, 0, 84, 60), 1'b0, STAT_OK),
      do_reg(REG_SECTOR_SHIFT, 48'd0),
      do_cmd(cmd(OP_QUERY, 0, 0, 0, SECTOR_MAX, '1), 1'b0, STAT_OK),
      do_cmd(cmd(OP_QUERY, 0, 0, 0, 48'h1_0000_0013, 3), 1'b0, STAT_OK),
      do_reg(REG_PART_START, SECTOR_MAX),
      do_cmd(cmd(OP_QUERY, 0, 0, 0, 5, 8), 1'b1, STAT_EARLY),
      do_cmd(cmd(OP_QUERY, 0, 0, 0, SECTOR_MAX, 0), 1'b0, STAT_OK),
      do_reg(REG_PART_START, 48'd0),
      do_reg(REG_SECTOR_SHIFT, 48'd7),
      do_cmd(cmd(OP_QUERY, 0, 0, 0, 48'd1280, 32'd127), 1'b0, STAT_OK),
      do_cmd(cmd(OP_QUERY, 0, 0, 0, 48'd0, '1), 1'b0, STAT_OK),
      do_reg(REG_SECTOR_SHIFT, 48'd3)
    };

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows
    foreach (steps[i]) begin
      if (steps[i].is_reg) begin
        write_reg(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        base = pending_pieces.size();
        send_command(steps[i].cmd);
        if (steps[i].typed && pending_pieces.size() == base + 1)
          pending_pieces[$] = status_only(steps[i].typed_status);
      end
    end

    // Load a run of sparse blocks, then split a wide range past the piece limit
    send_command(cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < FILL_COUNT; i++)
      send_command(cmd(OP_LOAD, 32'(2 * i), 0, 32'(i + 1), 0, 0));
    send_command(cmd(OP_QUERY, 0, 0, 0, 48'd8, 32'd1600));
    send_command(cmd(OP_QUERY, 0, 0, 0, 48'd65512, 32'd40));
    send_command(cmd(OP_CLEAR, 0, 0, 0, 0, 0));

    // Random phases: sender idles, then more often, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 31 : (ph == 1) ? 58 : 0;
      case (ph)
        0: begin
          write_reg(REG_PART_START, $urandom_range(0, 1 << 20));
          write_reg(REG_SECTOR_SHIFT, $urandom_range(0, 7));
        end
        1: begin
          write_reg(REG_PART_START, 48'd0);
          write_reg(REG_SECTOR_SHIFT, 48'd7);
        end
        default: begin
          write_reg(REG_PART_START, 48'hFFFF_0000_0000);
          write_reg(REG_SECTOR_SHIFT, 48'd0);
        end
      endcase
      for (int n = 0; n < 125; n++) send_command(random_cmd());
    end

    // Drain outstanding results
    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (pending_pieces.size() != 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+sv
sv/brem_pkg.sv
sv/brem_table.sv
sv/block_range_extent_mapper.sv
sim/testbench.sv
